@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Both forms sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/clte_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package clte_pkg;

  typedef enum logic [1:0] {
    ACT_SELECT,
    ACT_UP,
    ACT_DOWN,
    ACT_PRESET
  } action_t;

  // Field numbers
  localparam logic [3:0] FLD_NONE       = 4'd0;
  localparam logic [3:0] FLD_YEAR       = 4'd1;
  localparam logic [3:0] FLD_MONTH      = 4'd2;
  localparam logic [3:0] FLD_DAY        = 4'd3;
  localparam logic [3:0] FLD_HOUR       = 4'd4;
  localparam logic [3:0] FLD_MINUTE     = 4'd5;
  localparam logic [3:0] FLD_SECOND     = 4'd6;
  localparam logic [3:0] FLD_WEEKDAY    = 4'd7;
  localparam logic [3:0] FLD_ALARM_HOUR = 4'd8;
  localparam logic [3:0] FLD_ALARM_MIN  = 4'd9;
  localparam logic [4:0] FLD_END        = 5'd10;

  // Display modes
  localparam logic [2:0] MODE_HOME    = 3'd1;
  localparam logic [2:0] MODE_LAST    = 3'd3;
  localparam logic [2:0] MODE_SETTING = 3'd4;
  localparam logic [2:0] MODE_ALARM   = 3'd5;

  localparam logic [4:0] MLEN_RESET = 5'd31;

  // LCD cursor commands
  localparam logic [7:0] CUR_NONE = 8'h00;
  localparam logic [7:0] CUR_YEAR = 8'h81;
  localparam logic [7:0] CUR_MON  = 8'h83;
  localparam logic [7:0] CUR_DAY  = 8'h85;
  localparam logic [7:0] CUR_HOUR = 8'h90;
  localparam logic [7:0] CUR_MIN  = 8'h92;
  localparam logic [7:0] CUR_SEC  = 8'h94;
  localparam logic [7:0] CUR_WDAY = 8'h97;

  typedef struct packed {
    logic [2:0] mode;
    logic       setting;
    logic [3:0] field;
    logic [6:0] edit;
    logic [4:0] mlen;
  } clte_state_t;

  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    logic [6:0] data;
  } clte_wr_t;

  function automatic logic [7:0] cursor_cmd(input logic [3:0] field);
    logic [7:0] c;
    case (field)
      FLD_YEAR:       c = CUR_YEAR;
      FLD_MONTH:      c = CUR_MON;
      FLD_DAY:        c = CUR_DAY;
      FLD_HOUR:       c = CUR_HOUR;
      FLD_MINUTE:     c = CUR_MIN;
      FLD_SECOND:     c = CUR_SEC;
      FLD_WEEKDAY:    c = CUR_WDAY;
      FLD_ALARM_HOUR: c = CUR_MIN;
      FLD_ALARM_MIN:  c = CUR_SEC;
      default:        c = CUR_NONE;
    endcase
    return c;
  endfunction

  // Days in the stored month; an invalid month keeps the current length.
  function automatic logic [4:0] month_len(input logic [6:0] month, input logic [6:0] year,
                                           input logic [4:0] cur);
    logic [4:0] l;
    case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: l = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    l = 5'd30;
      7'd2:    l = (year[1:0] != 2'b00) ? 5'd28 : 5'd29;
      default: l = cur;
    endcase
    return l;
  endfunction

  function automatic logic [6:0] field_lo(input logic [3:0] field);
    logic [6:0] v;
    case (field)
      FLD_YEAR, FLD_HOUR, FLD_ALARM_HOUR, FLD_MINUTE, FLD_SECOND, FLD_ALARM_MIN: v = 7'd0;
      default: v = 7'd1;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] field_hi(input logic [3:0] field, input logic [4:0] mlen);
    logic [6:0] v;
    case (field)
      FLD_YEAR:                              v = 7'd99;
      FLD_MONTH:                             v = 7'd12;
      FLD_DAY:                               v = {2'b00, mlen};
      FLD_HOUR, FLD_ALARM_HOUR:              v = 7'd23;
      FLD_MINUTE, FLD_SECOND, FLD_ALARM_MIN: v = 7'd59;
      default:                               v = 7'd7;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ sv/clte_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Nine-entry field store, cleared at reset, one write port.
module clte_store (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire clte_pkg::clte_wr_t wr,
  input  wire logic [3:0]        rd_addr,
  output logic [6:0]             rd_data,
  output logic [6:0]             year,
  output logic [6:0]             month
);

  logic [6:0] mem_r [1:9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 9; i++) begin
        mem_r[i] <= '0;
      end
    end else if (wr.en && wr.addr >= clte_pkg::FLD_YEAR && wr.addr <= clte_pkg::FLD_ALARM_MIN) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = (rd_addr >= clte_pkg::FLD_YEAR && rd_addr <= clte_pkg::FLD_ALARM_MIN) ?
                   mem_r[rd_addr] : '0;
  assign year    = mem_r[clte_pkg::FLD_YEAR];
  assign month   = mem_r[clte_pkg::FLD_MONTH];

endmodule

`default_nettype wire

@@ sv/clte_next.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Next-state logic for one key word.
module clte_next (
  input  wire clte_pkg::clte_state_t cur,
  input  wire logic [1:0]           action,
  input  wire logic [3:0]           preset_addr,
  input  wire logic [6:0]           preset_value,
  input  wire logic [6:0]           rd_data,
  input  wire logic [6:0]           year,
  input  wire logic [6:0]           month,
  output logic [3:0]                rd_addr,
  output clte_pkg::clte_state_t     nxt,
  output clte_pkg::clte_wr_t        wr,
  output logic                      write_valid
);

  logic [4:0]        fi_inc;
  logic [2:0]        mode_t;
  logic              set_t;
  logic [6:0]        lo;
  logic [6:0]        hi;
  logic signed [8:0] t;
  logic [6:0]        wrapped;
  logic              field_ok;

  assign fi_inc   = {1'b0, cur.field} + 5'd1;
  assign rd_addr  = fi_inc[3:0];
  assign field_ok = cur.setting && cur.field >= clte_pkg::FLD_YEAR &&
                    cur.field <= clte_pkg::FLD_ALARM_MIN;

  // Step by one, then wrap at the field limits.
  assign lo = clte_pkg::field_lo(cur.field);
  assign hi = clte_pkg::field_hi(cur.field, cur.mlen);
  assign t  = $signed({2'b00, cur.edit}) +
              ((clte_pkg::action_t'(action) == clte_pkg::ACT_UP) ? 9'sd1 : -9'sd1);

  always_comb begin
    if (t > $signed({2'b00, hi})) begin
      wrapped = lo;
    end else if (t < $signed({2'b00, lo})) begin
      wrapped = hi;
    end else begin
      wrapped = t[6:0];
    end
  end

  always_comb begin
    nxt         = cur;
    wr          = '0;
    write_valid = 1'b0;
    mode_t      = cur.mode;
    set_t       = cur.setting;
    case (clte_pkg::action_t'(action))
      clte_pkg::ACT_SELECT: begin
        if (!set_t) begin
          if (mode_t <= clte_pkg::MODE_LAST) begin
            mode_t = mode_t + 3'd1;
          end
          if (mode_t == clte_pkg::MODE_SETTING) begin
            set_t = 1'b1;
          end
        end
        nxt.mode    = mode_t;
        nxt.setting = set_t;
        if (set_t) begin
          if (fi_inc >= clte_pkg::FLD_END) begin
            nxt.field   = clte_pkg::FLD_NONE;
            nxt.setting = 1'b0;
            nxt.mode    = clte_pkg::MODE_HOME;
            nxt.edit    = '0;
          end else begin
            nxt.field = fi_inc[3:0];
            nxt.edit  = rd_data;
            if (fi_inc[3:0] == clte_pkg::FLD_DAY) begin
              nxt.mlen = clte_pkg::month_len(month, year, cur.mlen);
            end
            if (fi_inc[3:0] == clte_pkg::FLD_ALARM_HOUR) begin
              nxt.mode = clte_pkg::MODE_ALARM;
            end
          end
        end
      end
      clte_pkg::ACT_UP, clte_pkg::ACT_DOWN: begin
        if (field_ok) begin
          nxt.edit    = wrapped;
          wr.en       = 1'b1;
          wr.addr     = cur.field;
          wr.data     = wrapped;
          write_valid = 1'b1;
        end
      end
      clte_pkg::ACT_PRESET: begin
        if (preset_addr >= clte_pkg::FLD_YEAR && preset_addr <= clte_pkg::FLD_ALARM_MIN) begin
          wr.en   = 1'b1;
          wr.addr = preset_addr;
          wr.data = preset_value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/clock_time_set_editor_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall   action, preset_addr, preset_value
// out_      output     out_valid / out_stall mode_now, setting_active, field_sel,
//                                            edit_value, cursor_cmd, write_*
//
// Flow: one key word per cycle while out_stall is low; an accepted word passes through the
//   input register, then the result register, where its result shows.
// The rate is set by the update of the editor state, done as the word moves
//   from the input register to the result register.
// Reset (rst_n low, synchronous): display mode 1, setting mode off, no field selected,
//   edit value 0, month length 31, all nine stored fields 0.
// Stalls: out_stall holds the result register; the input register still takes one more
//   word, then in_stall rises until the result is taken.
module clock_time_set_editor_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_action,
  input  wire logic [3:0] in_preset_addr,
  input  wire logic [6:0] in_preset_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_mode_now,
  output logic            out_setting_active,
  output logic [3:0]      out_field_sel,
  output logic [6:0]      out_edit_value,
  output logic [7:0]      out_cursor_cmd,
  output logic            out_write_valid,
  output logic [3:0]      out_write_addr,
  output logic [6:0]      out_write_value
);

  // Input register
  logic       s1_valid_r;
  logic [1:0] s1_action_r;
  logic [3:0] s1_paddr_r;
  logic [6:0] s1_pval_r;

  // Editor state
  clte_pkg::clte_state_t state_r;
  clte_pkg::clte_state_t state_nxt;

  // Result register
  logic       out_valid_r;
  logic [2:0] out_mode_r;
  logic       out_setting_r;
  logic [3:0] out_field_r;
  logic [6:0] out_edit_r;
  logic [7:0] out_cursor_r;
  logic       out_wvalid_r;
  logic [3:0] out_waddr_r;
  logic [6:0] out_wvalue_r;

  logic                  advance;
  logic                  in_take;
  logic [3:0]            rd_addr;
  logic [6:0]            rd_data;
  logic [6:0]            st_year;
  logic [6:0]            st_month;
  clte_pkg::clte_wr_t    st_wr;
  clte_pkg::clte_wr_t    st_wr_gated;
  logic                  write_valid;

  // Advance the held word when the result register is empty or being drained.
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  clte_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (st_wr_gated),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .year    (st_year),
    .month   (st_month)
  );

  clte_next u_next (
    .cur          (state_r),
    .action       (s1_action_r),
    .preset_addr  (s1_paddr_r),
    .preset_value (s1_pval_r),
    .rd_data      (rd_data),
    .year         (st_year),
    .month        (st_month),
    .rd_addr      (rd_addr),
    .nxt          (state_nxt),
    .wr           (st_wr),
    .write_valid  (write_valid)
  );

  // Commit a store write only when the word actually moves on.
  always_comb begin
    st_wr_gated    = st_wr;
    st_wr_gated.en = st_wr.en && advance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{mode: clte_pkg::MODE_HOME, setting: 1'b0,
                       field: clte_pkg::FLD_NONE, edit: 7'd0,
                       mlen: clte_pkg::MLEN_RESET};
    end else begin
      s1_valid_r  <= in_take || (s1_valid_r && !advance);
      out_valid_r <= advance || (out_valid_r && out_stall);
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_action;
      s1_paddr_r  <= in_preset_addr;
      s1_pval_r   <= in_preset_value;
    end
    if (advance) begin
      out_mode_r    <= state_nxt.mode;
      out_setting_r <= state_nxt.setting;
      out_field_r   <= state_nxt.field;
      out_edit_r    <= state_nxt.edit;
      out_cursor_r  <= clte_pkg::cursor_cmd(state_nxt.field);
      out_wvalid_r  <= write_valid;
      out_waddr_r   <= write_valid ? st_wr.addr : clte_pkg::FLD_NONE;
      out_wvalue_r  <= write_valid ? st_wr.data : 7'd0;
    end
  end

  assign out_mode_now       = out_mode_r;
  assign out_setting_active = out_setting_r;
  assign out_field_sel      = out_field_r;
  assign out_edit_value     = out_edit_r;
  assign out_cursor_cmd     = out_cursor_r;
  assign out_write_valid    = out_wvalid_r;
  assign out_write_addr     = out_waddr_r;
  assign out_write_value    = out_wvalue_r;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_idle_no_field,
    state_r.setting || state_r.field == clte_pkg::FLD_NONE,
    "field selected outside setting mode")
  `ASSERT_ALWAYS(a_setting_field_range,
    !state_r.setting || (state_r.field >= clte_pkg::FLD_YEAR &&
                         state_r.field <= clte_pkg::FLD_ALARM_MIN),
    "setting mode without a valid field")
  `ASSERT_ALWAYS(a_mode_range,
    state_r.mode >= clte_pkg::MODE_HOME && state_r.mode <= clte_pkg::MODE_ALARM,
    "display mode out of range")
  `ASSERT_ALWAYS(a_write_in_setting,
    !(out_valid_r && out_wvalid_r) || out_setting_r,
    "field write outside setting mode")
  `ASSERT_NEXT(a_state_hold, !advance, $stable(state_r),
    "state changed without a word advancing")

endmodule

`default_nettype wire
